// File: src/astar_open_list_table_core_defines.svh
// Assertion macros for the open-list table checker.
// Needs clk and arst_n in scope where the macros are used.
`ifndef ASTAR_OPEN_LIST_TABLE_CORE_DEFINES_SVH
`define ASTAR_OPEN_LIST_TABLE_CORE_DEFINES_SVH

// same-cycle implication, muted during reset
`define AOLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, muted during reset
`define AOLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/aolt_pkg.sv
// Shared types and constants of the open-list table.
// Used by every module of the block; depends on nothing.
package aolt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int SLOTS_MAX = 64;
	localparam int IDX_MW    = $clog2(SLOTS_MAX);
	localparam int COST_BITS = 20;
	localparam int Y_W       = 16;
	localparam int SLOT_FW   = 3;
	localparam int ORD_FW    = 3;
	localparam int CNT_FW    = 4;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_FIND   = 2'd2,
		FN_LOWEST = 2'd3
	} fn_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_NO_ORDER = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		fn_t                  func;
		logic [SLOT_FW-1:0]   slot;
		logic [Y_W-1:0]       coord_y;
		logic [COST_BITS-1:0] cost_f;
		logic [COST_BITS-1:0] cost_g;
		logic [COST_BITS-1:0] cost_h;
		logic [ORD_FW-1:0]    order_id;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_FW-1:0]   hit_slot;
		logic [Y_W-1:0]       out_y;
		logic [COST_BITS-1:0] out_f;
		logic [COST_BITS-1:0] out_g;
		logic [COST_BITS-1:0] out_h;
		logic [ORD_FW-1:0]    out_order;
		logic [CNT_FW-1:0]    entry_count;
	} rsp_t;

	typedef struct packed {
		logic [Y_W-1:0]       y;
		logic [COST_BITS-1:0] f;
		logic [COST_BITS-1:0] g;
		logic [COST_BITS-1:0] h;
	} ent_t;

	// candidate handed from cell to cell during a scan
	typedef struct packed {
		logic              hit;
		logic              fresh;
		logic [IDX_MW-1:0] idx;
		logic [IDX_MW-1:0] ord;
		ent_t              ent;
	} cand_t;

	// operation held steady for the whole scan
	typedef struct packed {
		fn_t               func;
		logic [IDX_MW-1:0] slot;
		logic [ORD_FW-1:0] want;
		logic [IDX_MW-1:0] nord;
		ent_t              ent;
	} cmd_t;

	// one-cycle removal commit broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [IDX_MW-1:0] slot;
		logic [IDX_MW-1:0] gone;
	} commit_t;

endpackage

// File: src/aolt_cell.sv
// One slot of the open-list table: stored entry plus one scan step.
// Depends on aolt_pkg.
module aolt_cell import aolt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX   = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  commit_t commit,
	input  logic    tok_in,
	input  cand_t   cand_in,
	output logic    tok_out,
	output cand_t   cand_out
);

	localparam int ORD_W = $clog2(SLOTS);

	logic             live_q;
	ent_t             ent_q;
	logic [ORD_W-1:0] ord_q;
	logic             tok_q;
	cand_t            cand_q;

	logic              mine;
	logic              write_add;
	logic [IDX_MW-1:0] own_ord;
	cand_t             own;
	cand_t             pick;

	always_comb begin
		mine      = (cmd.slot == IDX_MW'(IDX));
		write_add = tok_in && (cmd.func == FN_ADD) && mine;
		own_ord   = IDX_MW'(ord_q);
		own.hit   = 1'b1;
		own.fresh = 1'b0;
		own.idx   = IDX_MW'(IDX);
		own.ord   = own_ord;
		own.ent   = ent_q;
		pick      = cand_in;
		unique case (cmd.func)
			FN_ADD: begin
				if (mine) begin
					pick.hit   = 1'b1;
					pick.fresh = !live_q;
					pick.idx   = IDX_MW'(IDX);
					pick.ord   = live_q ? own_ord : cmd.nord;
					pick.ent   = cmd.ent;
				end
			end
			FN_REMOVE: begin
				if (mine) begin
					pick     = own;
					pick.hit = live_q;
				end
			end
			FN_FIND: begin
				// first live match along the chain wins
				if (!cand_in.hit && live_q && own_ord == IDX_MW'(cmd.want)) begin
					pick = own;
				end
			end
			FN_LOWEST: begin
				if (live_q && (!cand_in.hit || ent_q.f < cand_in.ent.f ||
					(ent_q.f == cand_in.ent.f && own_ord < cand_in.ord))) begin
					pick = own;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (write_add) begin
				live_q <= 1'b1;
			end else if (commit.en && commit.slot == IDX_MW'(IDX)) begin
				live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			cand_q <= pick;
		end
		if (write_add) begin
			ent_q <= cmd.ent;
			if (!live_q) begin
				ord_q <= ORD_W'(cmd.nord);
			end
		end else if (commit.en && live_q && own_ord > commit.gone) begin
			// close the gap left by the removed entry
			ord_q <= ord_q - 1'b1;
		end
	end

	assign tok_out  = tok_q;
	assign cand_out = cand_q;

endmodule

// File: src/aolt_ctrl.sv
// Sequencer of the open-list table: takes an item, launches the scan,
// builds the result and commits removals. Depends on aolt_pkg.
module aolt_ctrl import aolt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  req_t    req,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output rsp_t    rsp,
	output cmd_t    cmd,
	output commit_t commit,
	output logic    head_tok,
	input  logic    tail_tok,
	input  cand_t   tail_cand
);

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int VW    = IDX_MW + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	logic             start_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             rsp_valid_q;
	cmd_t             cmd_q;
	cand_t            res_q;
	rsp_t             rsp_q;
	rsp_t             rsp_nxt;

	logic [VW-1:0] slot_v;
	logic          accept;
	logic          rsp_free;
	logic          fin;

	// reduce the slot number modulo SLOTS
	always_comb begin
		slot_v = VW'(req.slot);
		for (int k = 0; k < 4; k++) begin
			if (slot_v >= VW'(SLOTS)) begin
				slot_v = slot_v - VW'(SLOTS);
			end
		end
	end

	assign accept    = req_valid && (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign fin       = (state_q == S_FIN) && rsp_free;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cnt_nxt = cnt_q;
		if (fin) begin
			if (cmd_q.func == FN_ADD && res_q.fresh) begin
				cnt_nxt = cnt_q + 1'b1;
			end else if (cmd_q.func == FN_REMOVE && res_q.hit) begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		rsp_nxt             = '0;
		rsp_nxt.entry_count = CNT_FW'(cnt_nxt);
		if (res_q.hit) begin
			rsp_nxt.status    = ST_OK;
			rsp_nxt.hit_slot  = SLOT_FW'(res_q.idx);
			rsp_nxt.out_y     = res_q.ent.y;
			rsp_nxt.out_f     = res_q.ent.f;
			rsp_nxt.out_g     = res_q.ent.g;
			rsp_nxt.out_h     = res_q.ent.h;
			rsp_nxt.out_order = ORD_FW'(res_q.ord);
		end else begin
			unique case (cmd_q.func)
				FN_ADD:    rsp_nxt.status = ST_OK;
				FN_REMOVE: begin
					rsp_nxt.status   = ST_NO_SLOT;
					rsp_nxt.hit_slot = SLOT_FW'(cmd_q.slot);
				end
				FN_FIND:   rsp_nxt.status = ST_NO_ORDER;
				FN_LOWEST: rsp_nxt.status = ST_EMPTY;
			endcase
		end
	end

	always_comb begin
		commit.en   = fin && (cmd_q.func == FN_REMOVE) && res_q.hit;
		commit.slot = cmd_q.slot;
		commit.gone = res_q.ord;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_nxt = S_SCAN;
			S_SCAN:  if (tail_tok) state_nxt = S_FIN;
			S_FIN:   if (rsp_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= accept;
			cnt_q   <= cnt_nxt;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.func  <= req.func;
			cmd_q.slot  <= IDX_MW'(slot_v);
			cmd_q.want  <= req.order_id;
			cmd_q.nord  <= IDX_MW'(cnt_q);
			cmd_q.ent.y <= req.coord_y;
			cmd_q.ent.f <= req.cost_f;
			cmd_q.ent.g <= req.cost_g;
			cmd_q.ent.h <= req.cost_h;
		end
		if (state_q == S_SCAN && tail_tok) begin
			res_q <= tail_cand;
		end
		if (fin) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign cmd       = cmd_q;
	assign head_tok  = start_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/astar_open_list_table_core.sv
// Open-list table of a path search: one cell per slot in a chain, with a
// sequencer in front. Each item (add, remove, find by order number, lowest f)
// sends one token down the chain, one cell a cycle, and no new item is taken
// until that token has left the last cell and the result has been registered.
// The result sits in an output register, and the next item is taken while it
// waits. There is no clearing pass after reset. Depends on aolt_pkg, aolt_ctrl
// and aolt_cell.
module astar_open_list_table_core import aolt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t    cmd;
	commit_t commit;
	logic    tok_chain  [SLOTS+1];
	cand_t   cand_chain [SLOTS+1];

	aolt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.commit    (commit),
		.head_tok  (tok_chain[0]),
		.tail_tok  (tok_chain[SLOTS]),
		.tail_cand (cand_chain[SLOTS])
	);

	assign cand_chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		aolt_cell #(.SLOTS(SLOTS), .IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.commit   (commit),
			.tok_in   (tok_chain[i]),
			.cand_in  (cand_chain[i]),
			.tok_out  (tok_chain[i+1]),
			.cand_out (cand_chain[i+1])
		);
	end

endmodule

// File: src/aolt_chk.sv
// Port-level checker of the open-list table, bound to the top level.
// Depends on aolt_pkg and astar_open_list_table_core_defines.svh.
`include "astar_open_list_table_core_defines.svh"

module aolt_chk import aolt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic in_take;
	logic rsp_wait;
	logic count_ok;
	logic miss;
	logic data_zero;

	assign in_take   = req_valid && !req_stall;
	assign rsp_wait  = rsp_valid && rsp_stall;
	assign count_ok  = (SLOTS > 15) || (rsp.entry_count <= CNT_FW'(SLOTS));
	assign miss      = rsp_valid && (rsp.status != ST_OK);
	assign data_zero = (rsp.out_y == '0) && (rsp.out_f == '0) && (rsp.out_g == '0) &&
		(rsp.out_h == '0) && (rsp.out_order == '0);

	`AOLT_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "stalled result changed")
	`AOLT_ASSERT_NEXT(a_busy_after_accept, in_take, req_stall, "item taken while a scan runs")
	`AOLT_ASSERT_NOW(a_count_bound, rsp_valid, count_ok, "entry count above table size")
	`AOLT_ASSERT_NOW(a_miss_zero, miss, data_zero, "failed item carries entry data")

endmodule

bind astar_open_list_table_core aolt_chk #(.SLOTS(SLOTS)) u_aolt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
